// ----- rtl/cft_pkg.sv -----
// cft_pkg: shared types and constants for the csv field tokenizer
// holds the front-to-back command word, config and result structs
// no dependencies
package cft_pkg;

    // default depth of the leading-blank buffer
    localparam int PadDepthDef = 8;
    // entries in the command queue between front and back
    localparam int QueueDepth = 4;

    // fixed character codes
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChSp  = 8'h20;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChNul = 8'h00;

    // config register indexes
    typedef enum logic [1:0] {
        CFG_SEPARATOR = 2'd0,
        CFG_QUOTE     = 2'd1,
        CFG_ESC_ON    = 2'd2,
        CFG_ESC_CHAR  = 2'd3
    } t_cfg_idx;

    // record prefix classes for null-field detection
    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_CR    = 2'd1,
        PFX_LF    = 2'd2,
        PFX_OTHER = 2'd3
    } t_prefix;

    typedef struct packed {
        logic [7:0] separator;
        logic [7:0] quote;
        logic       esc_on;
        logic [7:0] esc_char;
    } t_cfg;

    // one classified input word, expanded by the back end
    typedef struct packed {
        logic       push_pad;   // store a leading blank
        logic       push_tab;   // stored blank is a tab, else a space
        logic       clear_pad;  // drop held blanks
        logic       flush;      // emit held blanks first
        logic       emit_byte;  // emit data as a field byte
        logic       ovf;        // emit an overflow mark
        logic       field;      // emit a field-end mark
        logic       nul;        // emit a zero byte before the record mark
        logic       rec;        // emit the record-end mark
        logic       rec_null;   // record-end mark carries the null flag
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       fdone;
        logic       rdone;
        logic       nul;
        logic       ovf;
        logic       last;
    } t_res;

endpackage

// ----- rtl/cft_front.sv -----
// cft_front: accepts input words, tracks the quoting state, issues commands
// depends on cft_pkg
module cft_front import cft_pkg::*; #(
    parameter int PAD_DEPTH = PadDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // in_byte
    input  logic       i_s_tlast,   // in_last
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int CW = $clog2(PAD_DEPTH + 1);

    logic          r_inq, n_inq;
    logic          r_fstart, n_fstart;
    logic          r_closep, n_closep;
    logic          r_escp, n_escp;
    logic          r_escodd, n_escodd;
    logic          r_lended, n_lended;
    t_prefix       r_prefix, n_prefix;
    logic [CW-1:0] r_cnt, n_cnt;
    t_cmd          cmd;
    logic          acc;

    assign o_s_tready = !i_full;
    assign acc        = i_s_tvalid && !i_full;

    // classify one word and work out the next state
    always_comb begin
        logic [7:0] b;
        logic       last;
        logic       unq;
        logic       blank;
        b     = i_s_tdata;
        last  = i_s_tlast;
        unq   = 1'b0;
        blank = (b == ChSp) || (b == ChTab);
        n_inq    = r_inq;
        n_fstart = r_fstart;
        n_closep = r_closep;
        n_escp   = r_escp;
        n_escodd = r_escodd;
        n_lended = r_lended;
        n_cnt    = r_cnt;
        cmd      = '0;
        cmd.data = b;

        // prefix class of the record so far
        unique case (r_prefix)
            PFX_NONE:  n_prefix = (b == ChCr) ? PFX_CR : (b == ChLf) ? PFX_LF : PFX_OTHER;
            PFX_CR:    n_prefix = (b == ChLf) ? PFX_LF : PFX_OTHER;
            default:   n_prefix = PFX_OTHER;
        endcase

        // quoted-field handling and pending lookahead
        if (!r_lended) begin
            if (r_closep) begin
                n_closep = 1'b0;
                if (b == i_cfg.quote) begin
                    cmd.emit_byte = 1'b1;
                    n_escodd = (b == i_cfg.esc_char) ? !r_escodd : 1'b0;
                end else begin
                    n_inq    = 1'b0;
                    n_fstart = 1'b0;
                    unq      = 1'b1;
                end
            end else if (r_escp) begin
                n_escp = 1'b0;
                cmd.emit_byte = 1'b1;
                n_escodd = (b == i_cfg.esc_char) ? !r_escodd : 1'b0;
            end else if (r_inq) begin
                if (b == i_cfg.quote) begin
                    if (i_cfg.esc_on && r_escodd) begin
                        cmd.emit_byte = 1'b1;
                        n_escodd = (b == i_cfg.esc_char) ? !r_escodd : 1'b0;
                    end else if (last) begin
                        n_inq    = 1'b0;
                        n_fstart = 1'b0;
                    end else begin
                        n_closep = 1'b1;
                    end
                end else begin
                    cmd.emit_byte = 1'b1;
                    n_escodd = (b == i_cfg.esc_char) ? !r_escodd : 1'b0;
                    if (i_cfg.esc_on && b == i_cfg.esc_char && !last)
                        n_escp = 1'b1;
                end
            end else begin
                unq = 1'b1;
            end
        end

        // unquoted byte handling
        if (unq) begin
            if (b == ChLf || b == ChCr) begin
                cmd.flush = (r_cnt != '0);
                n_cnt     = '0;
                n_lended  = 1'b1;
            end else if (n_fstart && b == i_cfg.quote) begin
                cmd.clear_pad = (r_cnt != '0);
                n_cnt    = '0;
                n_inq    = 1'b1;
                n_fstart = 1'b0;
                n_escodd = 1'b0;
            end else if (n_fstart && b != i_cfg.separator && blank) begin
                if (last) begin
                    cmd.flush     = (r_cnt != '0);
                    cmd.emit_byte = 1'b1;
                    n_cnt         = '0;
                end else if (r_cnt < CW'(PAD_DEPTH)) begin
                    cmd.push_pad = 1'b1;
                    cmd.push_tab = (b == ChTab);
                    n_cnt        = r_cnt + CW'(1);
                end else begin
                    cmd.ovf = 1'b1;
                end
            end else if (b == i_cfg.separator) begin
                cmd.flush = (r_cnt != '0);
                cmd.field = 1'b1;
                n_cnt     = '0;
                n_fstart  = 1'b1;
            end else begin
                cmd.flush     = (r_cnt != '0);
                cmd.emit_byte = 1'b1;
                n_cnt         = '0;
                n_fstart      = 1'b0;
            end
        end

        // record end: closing marks and state clear
        if (last) begin
            cmd.rec = 1'b1;
            if (n_prefix == PFX_CR || n_prefix == PFX_LF) begin
                cmd.rec_null  = 1'b1;
                cmd.clear_pad = (n_cnt != '0);
            end else begin
                cmd.flush = cmd.flush || (n_cnt != '0);
                cmd.nul   = n_inq && i_cfg.esc_on && (i_cfg.esc_char == ChNul);
            end
            n_inq    = 1'b0;
            n_fstart = 1'b1;
            n_closep = 1'b0;
            n_escp   = 1'b0;
            n_escodd = 1'b0;
            n_lended = 1'b0;
            n_prefix = PFX_NONE;
            n_cnt    = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = acc && (cmd.push_pad || cmd.clear_pad || cmd.flush || cmd.emit_byte ||
                            cmd.ovf || cmd.field || cmd.nul || cmd.rec);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq    <= 1'b0;
            r_fstart <= 1'b1;
            r_closep <= 1'b0;
            r_escp   <= 1'b0;
            r_escodd <= 1'b0;
            r_lended <= 1'b0;
            r_prefix <= PFX_NONE;
            r_cnt    <= '0;
        end else if (acc) begin
            r_inq    <= n_inq;
            r_fstart <= n_fstart;
            r_closep <= n_closep;
            r_escp   <= n_escp;
            r_escodd <= n_escodd;
            r_lended <= n_lended;
            r_prefix <= n_prefix;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// ----- rtl/cft_queue.sv -----
// cft_queue: small command fifo between front and back
// depends on cft_pkg
module cft_queue import cft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = $clog2(QueueDepth);

    t_cmd        r_mem [QueueDepth];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW + 1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_cmd;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + AW'(1);
            if (do_pop)
                r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW + 1)'(i_push) - (AW + 1)'(do_pop);
        end
    end

endmodule

// ----- rtl/cft_back.sv -----
// cft_back: expands queued commands into result words, owns the blank buffer
// depends on cft_pkg
module cft_back import cft_pkg::*; #(
    parameter int PAD_DEPTH = PadDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output t_res       o_res,
    output logic       o_res_valid,
    input  logic       i_res_ready
);

    localparam int CW = $clog2(PAD_DEPTH + 1);
    localparam int IW = (PAD_DEPTH > 1) ? $clog2(PAD_DEPTH) : 1;

    logic [PAD_DEPTH-1:0] r_pad;     // 1 = tab, 0 = space, entry 0 leaves first
    logic [CW-1:0]        r_cnt;
    logic                 r_main_done, r_nul_done;
    logic                 r_out_valid;
    t_res                 r_out;

    logic out_free, fl, mn, nl, rc, emit, pop;
    t_res res;

    assign out_free = !r_out_valid || i_res_ready;
    assign fl = i_cmd.flush && (r_cnt != '0);
    assign mn = (i_cmd.emit_byte || i_cmd.ovf || i_cmd.field) && !r_main_done;
    assign nl = i_cmd.nul && !r_nul_done;
    assign rc = i_cmd.rec;

    // pick the next result of the head command
    always_comb begin
        res  = '0;
        emit = 1'b0;
        pop  = 1'b0;
        if (i_valid) begin
            priority if (fl) begin
                emit      = 1'b1;
                res.data  = r_pad[0] ? ChTab : ChSp;
                res.valid = 1'b1;
                res.last  = (r_cnt == CW'(1)) && !mn && !nl && !rc;
                pop       = res.last;
            end else if (mn) begin
                emit      = 1'b1;
                res.data  = i_cmd.emit_byte ? i_cmd.data : 8'h00;
                res.valid = i_cmd.emit_byte;
                res.ovf   = i_cmd.ovf;
                res.fdone = i_cmd.field;
                res.last  = !nl && !rc;
                pop       = res.last;
            end else if (nl) begin
                emit      = 1'b1;
                res.data  = ChNul;
                res.valid = 1'b1;
                res.last  = !rc;
                pop       = res.last;
            end else if (rc) begin
                emit      = 1'b1;
                res.fdone = 1'b1;
                res.rdone = 1'b1;
                res.nul   = i_cmd.rec_null;
                res.last  = 1'b1;
                pop       = 1'b1;
            end else begin
                pop = 1'b1;
            end
        end
    end

    assign o_pop       = pop && (!emit || out_free);
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    // blank buffer, progress flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_main_done <= 1'b0;
            r_nul_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free)
                r_out_valid <= emit;
            // blank buffer: push, drop when the command leaves, shift out on a flush
            if (i_valid && !emit && i_cmd.push_pad) begin
                r_pad[r_cnt[IW-1:0]] <= i_cmd.push_tab;
                r_cnt <= r_cnt + CW'(1);
            end else if (o_pop && i_cmd.clear_pad) begin
                r_cnt <= '0;
            end else if (emit && out_free && fl) begin
                r_pad <= r_pad >> 1;
                r_cnt <= r_cnt - CW'(1);
            end
            // progress through the head command
            if (o_pop) begin
                r_main_done <= 1'b0;
                r_nul_done  <= 1'b0;
            end else if (emit && out_free && !fl) begin
                if (mn)
                    r_main_done <= 1'b1;
                else if (nl)
                    r_nul_done <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free && emit)
            r_out <= res;
    end

endmodule

// ----- rtl/csv_field_tokenizer_top.sv -----
// csv_field_tokenizer_top: csv record tokenizer, one byte in per cycle unless the queue is full
// path: an accepted byte's command is written to the command queue; with the queue empty,
// the back end then registers the first result of the byte on the output register
// input rate: one byte per cycle while the queue is not full; a byte giving several
// results holds the back end until its last one is out; the 4-entry queue absorbs bursts
// reset: synchronous active low; clears parser state, queue and blank count, config to defaults
// depends on cft_pkg, cft_front, cft_queue, cft_back
module csv_field_tokenizer_top import cft_pkg::*; #(
    parameter int PAD_DEPTH = PadDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    // result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [4:0] o_m_tuser,   // [0] byte_valid [1] field_done [2] record_done
                                    // [3] null_field [4] pad_overflow
    output logic       o_m_tlast    // run_last
);

    t_cfg r_cfg;
    logic q_full, q_push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;
    t_res res;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator <= 8'd44;
            r_cfg.quote     <= 8'd34;
            r_cfg.esc_on    <= 1'b1;
            r_cfg.esc_char  <= 8'd92;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEPARATOR: r_cfg.separator <= i_cfg_data;
                CFG_QUOTE:     r_cfg.quote     <= i_cfg_data;
                CFG_ESC_ON:    r_cfg.esc_on    <= i_cfg_data[0];
                CFG_ESC_CHAR:  r_cfg.esc_char  <= i_cfg_data;
                default:       r_cfg.esc_char  <= r_cfg.esc_char;
            endcase
        end
    end

    cft_front #(.PAD_DEPTH(PAD_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    cft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cft_back #(.PAD_DEPTH(PAD_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_res       (res),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready)
    );

    // result word packing
    assign o_m_tdata = res.data;
    assign o_m_tuser = {res.ovf, res.nul, res.rdone, res.fdone, res.valid};
    assign o_m_tlast = res.last;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for csv_field_tokenizer_top
// predicts field bytes and field/record marks per accepted word and checks them in order
// depends on cft_pkg and the csv_field_tokenizer_top rtl
`timescale 1ns / 1ps

module tb;
    import cft_pkg::*;

    localparam int BLANK_DEPTH = PadDepthDef;
    localparam int MAX_TOKENS  = BLANK_DEPTH + 2;
    localparam int PHASE_BYTES = 52;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = '0;   // [7:0] in_byte
    logic       i_s_tlast   = 1'b0; // in_last
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;          // [7:0] out_byte
    logic [4:0] o_m_tuser;          // [0] byte_valid [1] field_done [2] record_done
                                    // [3] null_field [4] pad_overflow
    logic       o_m_tlast;          // run_last

    bit         idle_on  = 1'b1;
    bit         hold_req = 1'b0;
    logic [7:0] rec_bytes[$];
    t_res       out_word;

    // token predictor and in-order checker
    class tokenizer_scoreboard;
        logic [7:0] sep_char;
        logic [7:0] quote_char;
        logic       esc_on;
        logic [7:0] esc_char;
        bit         in_quotes;
        bit         field_start;
        bit         close_pend;
        bit         esc_pend;
        bit         esc_odd;
        bit         line_done;
        t_prefix    prefix;
        logic [7:0] blank_buf[BLANK_DEPTH];
        int         blank_cnt;
        t_res       step_q[$];
        t_res       token_q[$];
        int         errors;
        int         reports;

        function new();
            // register reset values: comma, double quote, backslash
            sep_char   = 8'd44;
            quote_char = 8'd34;
            esc_on     = 1'b1;
            esc_char   = 8'd92;
            errors     = 0;
            reports    = 0;
            blank_cnt  = 0;
            clear_record();
        endfunction

        function void clear_record();
            in_quotes   = 1'b0;
            field_start = 1'b1;
            close_pend  = 1'b0;
            esc_pend    = 1'b0;
            esc_odd     = 1'b0;
            line_done   = 1'b0;
            prefix      = PFX_NONE;
            blank_cnt   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] val);
            case (idx)
                CFG_SEPARATOR: sep_char   = val;
                CFG_QUOTE:     quote_char = val;
                CFG_ESC_ON:    esc_on     = val[0];
                CFG_ESC_CHAR:  esc_char   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return token_q.size();
        endfunction

        function void put_token(logic [7:0] b, bit v, bit fd, bit rd, bit nl, bit ov);
            t_res r;
            if (step_q.size() >= MAX_TOKENS) return;
            r.data  = v ? b : 8'h00;
            r.valid = v;
            r.fdone = fd;
            r.rdone = rd;
            r.nul   = nl;
            r.ovf   = ov;
            r.last  = 1'b0;
            step_q.push_back(r);
        endfunction

        // quoted byte out, tracking parity of the trailing escape run
        function void put_quoted(logic [7:0] b);
            put_token(b, 1, 0, 0, 0, 0);
            esc_odd = (b == esc_char) ? !esc_odd : 1'b0;
        endfunction

        function void flush_blanks();
            for (int i = 0; i < blank_cnt; i++) put_token(blank_buf[i], 1, 0, 0, 0, 0);
            blank_cnt = 0;
        endfunction

        function void unquoted_byte(logic [7:0] b, bit last);
            if (b == ChLf || b == ChCr) begin
                flush_blanks();
                line_done = 1'b1;
                return;
            end
            // opening quote drops held blanks
            if (field_start && b == quote_char) begin
                blank_cnt   = 0;
                in_quotes   = 1'b1;
                field_start = 1'b0;
                esc_odd     = 1'b0;
                return;
            end
            // leading blank: hold, or flush on the final byte, or overflow mark
            if (field_start && b != sep_char && (b == ChSp || b == ChTab)) begin
                if (last) begin
                    flush_blanks();
                    put_token(b, 1, 0, 0, 0, 0);
                end else if (blank_cnt < BLANK_DEPTH) begin
                    blank_buf[blank_cnt] = b;
                    blank_cnt++;
                end else begin
                    put_token(8'h00, 0, 0, 0, 0, 1);
                end
                return;
            end
            if (b == sep_char) begin
                flush_blanks();
                put_token(8'h00, 0, 1, 0, 0, 0);
                field_start = 1'b1;
                return;
            end
            flush_blanks();
            put_token(b, 1, 0, 0, 0, 0);
            field_start = 1'b0;
        endfunction

        function void quoted_byte(logic [7:0] b, bit last);
            if (b == quote_char) begin
                if (esc_on && esc_odd) begin
                    put_quoted(b);
                end else if (last) begin
                    in_quotes   = 1'b0;
                    field_start = 1'b0;
                end else begin
                    close_pend = 1'b1;
                end
                return;
            end
            if (esc_on && b == esc_char && !last) begin
                put_quoted(b);
                esc_pend = 1'b1;
                return;
            end
            put_quoted(b);
        endfunction

        // note an accepted word and queue the tokens it must produce
        function void note_byte(logic [7:0] b, bit last);
            step_q.delete();
            case (prefix)
                PFX_NONE: prefix = (b == ChCr) ? PFX_CR : (b == ChLf) ? PFX_LF : PFX_OTHER;
                PFX_CR:   prefix = (b == ChLf) ? PFX_LF : PFX_OTHER;
                default:  prefix = PFX_OTHER;
            endcase

            if (!line_done) begin
                if (close_pend) begin
                    close_pend = 1'b0;
                    if (b == quote_char) begin
                        put_quoted(b);
                    end else begin
                        in_quotes   = 1'b0;
                        field_start = 1'b0;
                        unquoted_byte(b, last);
                    end
                end else if (esc_pend) begin
                    esc_pend = 1'b0;
                    put_quoted(b);
                end else if (in_quotes) begin
                    quoted_byte(b, last);
                end else begin
                    unquoted_byte(b, last);
                end
            end

            // record end: null field for a bare line end, else flush and close
            if (last) begin
                if (prefix == PFX_CR || prefix == PFX_LF) begin
                    put_token(8'h00, 0, 1, 1, 1, 0);
                end else begin
                    flush_blanks();
                    if (in_quotes && esc_on && esc_char == ChNul) put_quoted(ChNul);
                    put_token(8'h00, 0, 1, 1, 0, 0);
                end
                clear_record();
            end

            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i]) token_q.push_back(step_q[i]);
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            if (want === got) return;
            errors++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_token(t_res got);
            t_res want;
            if (token_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: unexpected result expected none actual %0h", $time, got);
                end
                return;
            end
            want = token_q.pop_front();
            report_field("out_byte", want.data, got.data);
            report_field("byte_valid", 8'(want.valid), 8'(got.valid));
            report_field("field_done", 8'(want.fdone), 8'(got.fdone));
            report_field("record_done", 8'(want.rdone), 8'(got.rdone));
            report_field("null_field", 8'(want.nul), 8'(got.nul));
            report_field("pad_overflow", 8'(want.ovf), 8'(got.ovf));
            report_field("run_last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    tokenizer_scoreboard board;

    csv_field_tokenizer_top #(
        .PAD_DEPTH(BLANK_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result monitor
    assign out_word = {o_m_tdata, o_m_tuser[0], o_m_tuser[1], o_m_tuser[2],
                       o_m_tuser[3], o_m_tuser[4], o_m_tlast};

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_token(out_word);
    end

    // receiver: random stall bursts plus one long hold-off
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_word(logic [7:0] b, bit last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_byte(b, last);
    endtask

    task automatic send_record();
        int n;
        n = rec_bytes.size();
        for (int i = 0; i < n; i++) send_word(rec_bytes[i], i == n - 1);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out all predicted tokens, then the pipeline latency
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 7))
            0: return 8'd44;
            1: return 8'd34;
            2: return 8'd92;
            3: return ChSp;
            4: return ChTab;
            5: return ChNul;
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3: begin
                case ($urandom_range(0, 2))
                    0: return board.sep_char;
                    1: return board.quote_char;
                    default: return board.esc_char;
                endcase
            end
            4: return $urandom_range(0, 1) ? ChSp : ChTab;
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    // mostly well-formed records with random content, some noise and bare line ends
    function automatic void build_record();
        int kind;
        int nf;
        int nb;
        rec_bytes.delete();
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            case ($urandom_range(0, 3))
                0: rec_bytes = '{ChLf};
                1: rec_bytes = '{ChCr};
                2: rec_bytes = '{ChCr, ChLf};
                default: rec_bytes = '{ChCr, ChLf, pick_text()};
            endcase
            return;
        end
        if (kind == 1) begin
            repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) rec_bytes.push_back(board.sep_char);
            // leading blanks, now and then past the buffer depth
            case ($urandom_range(0, 9))
                6, 7:    nb = $urandom_range(1, 3);
                8:       nb = $urandom_range(BLANK_DEPTH, BLANK_DEPTH + 3);
                9:       nb = $urandom_range(4, BLANK_DEPTH - 1);
                default: nb = 0;
            endcase
            repeat (nb) rec_bytes.push_back($urandom_range(0, 1) ? ChSp : ChTab);
            if ($urandom_range(0, 1)) begin
                rec_bytes.push_back(board.quote_char);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            rec_bytes.push_back(board.quote_char);
                            rec_bytes.push_back(board.quote_char);
                        end
                        1: begin
                            rec_bytes.push_back(board.esc_char);
                            rec_bytes.push_back(pick_text());
                        end
                        2: begin
                            rec_bytes.push_back(board.esc_char);
                            rec_bytes.push_back(board.esc_char);
                        end
                        3: rec_bytes.push_back(board.quote_char);
                        default: rec_bytes.push_back(pick_text());
                    endcase
                end
                if ($urandom_range(0, 4) != 0) rec_bytes.push_back(board.quote_char);
            end else begin
                repeat ($urandom_range(0, 5)) rec_bytes.push_back(pick_text());
            end
        end
        case ($urandom_range(0, 5))
            0: rec_bytes.push_back(ChLf);
            1: begin
                rec_bytes.push_back(ChCr);
                rec_bytes.push_back(ChLf);
            end
            2: begin
                rec_bytes.push_back(ChCr);
                repeat ($urandom_range(1, 3)) rec_bytes.push_back(pick_text());
            end
            3: rec_bytes.push_back(board.esc_char);
            default: ;
        endcase
        if (rec_bytes.size() == 0) rec_bytes.push_back(pick_text());
    endfunction

    task automatic run_phase(logic [7:0] sep, logic [7:0] quo, bit eon, logic [7:0] esc,
                             bit long_hold);
        int sent;
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE, quo);
        write_reg(CFG_ESC_ON, {7'($urandom_range(0, 127)), eon});
        write_reg(CFG_ESC_CHAR, esc);
        if (long_hold) hold_req = 1'b1;
        sent = 0;
        while (sent < PHASE_BYTES) begin
            build_record();
            sent += rec_bytes.size();
            send_record();
        end
        drain_results();
    endtask

    // main sequence
    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed records under reset config
        // bare line ends give a null field
        rec_bytes = '{ChLf};
        send_record();
        rec_bytes = '{ChCr, ChLf};
        send_record();
        rec_bytes = '{ChCr};
        send_record();
        // blank before quote, doubled quote, escaped quote, close then separator,
        // late quote, line end and an ignored tail byte
        rec_bytes = '{ChSp, 8'h22, 8'h22, 8'h22, 8'h5C, 8'h22, 8'h61, 8'h22,
                      8'h2C, 8'h62, 8'h22, ChCr, 8'hFF};
        send_record();
        // escape on the final byte goes out as a plain byte
        rec_bytes = '{8'h22, 8'h78, 8'h5C};
        send_record();
        // quote on the final byte closes at once
        rec_bytes = '{8'h22, 8'h22};
        send_record();
        // held blank before a non-blank final byte
        rec_bytes = '{ChTab, ChNul};
        send_record();
        drain_results();

        // extremes, nul escape char for the end-inside-quotes case
        run_phase(ChNul, 8'hFF, 1'b1, ChNul, 1'b0);
        run_phase(8'hFF, ChNul, 1'b0, 8'hFF, 1'b0);
        // defaults with the long receiver hold-off
        run_phase(8'd44, 8'd34, 1'b1, 8'd92, 1'b1);
        // escape byte equal to the quote byte
        run_phase(8'h3B, 8'h27, 1'b1, 8'h27, 1'b0);
        run_phase(pick_special(), pick_special(), 1'($urandom_range(0, 1)), pick_special(),
                  1'b0);
        run_phase(pick_special(), pick_special(), 1'($urandom_range(0, 1)), pick_special(),
                  1'b0);
        // closing stretch at full rate
        idle_on = 1'b0;
        run_phase(8'd44, 8'd34, 1'b1, 8'd92, 1'b0);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
